// File: design/tws_pkg.sv
// tick window signal engine: shared types, field widths, register codes and reset values
// no dependencies; used by the top level
`default_nettype none

package tws_pkg;

  localparam int INST_W  = 8;
  localparam int PRICE_W = 24;
  localparam int BAND_W  = 6;
  localparam int SIG_W   = 2;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  localparam logic [PRICE_W-1:0] LOW_LIMIT_RESET  = 24'd10500;
  localparam logic [PRICE_W-1:0] HIGH_LIMIT_RESET = 24'd19500;
  localparam logic [BAND_W-1:0]  BAND_RESET       = 6'd2;

  localparam int MIN_AVG_COUNT  = 5;
  localparam int MIN_RISE_COUNT = 3;
  localparam logic [7:0] PERCENT = 8'd100;

  localparam int DEF_NUM_INSTRUMENTS = 256;
  localparam int DEF_WINDOW_LEN      = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 2'd0,
    CFG_HIGH_LIMIT = 2'd1,
    CFG_BAND       = 2'd2
  } cfg_idx_t;

  typedef enum logic [SIG_W-1:0] {
    SIG_NONE  = 2'd0,
    SIG_BAND  = 2'd1,
    SIG_AVG   = 2'd2,
    SIG_RISE  = 2'd3
  } sig_t;

  typedef struct packed {
    logic [INST_W-1:0]  inst_id;
    logic [PRICE_W-1:0] price;
  } tick_t;

  typedef struct packed {
    logic [INST_W-1:0]  order_instrument;
    logic [PRICE_W-1:0] order_price;
    logic               is_buy;
    logic [SIG_W-1:0]   trigger_signal;
  } order_t;

endpackage

`default_nettype wire

// File: design/tws_stream_if.sv
// valid/ready stream channel with a typed payload
// payload type is the parameter payload_t; the tick and order payload types come from tws_pkg
`default_nettype none

interface tws_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/tick_window_signal_engine.sv
// tick window signal engine top level: per-instrument windows in block memories,
// signal evaluation pipeline and an output queue
// depends on tws_pkg and tws_stream_if
`default_nettype none

// channel  dir  payload                                              request moves
// tick     in   inst_id, price                                       one market tick
// order    out  order_instrument, order_price, is_buy, trigger_signal one order
// cfg      in   cfg_we, cfg_index, cfg_data                          one register write
//
// one tick per cycle while tick.ready is high; an accepted tick passes stages s1-s4
// before it reaches the output queue. the metadata memory is read at acceptance and
// written back from stage s2, with forwarding from the two ticks ahead; the window
// entry at the head is read and overwritten in the same cycle, in stage s1 after acceptance.
// after reset a clearing pass zeroes the NUM_INSTRUMENTS metadata entries in turn;
// tick.ready stays low meanwhile. ready also drops when the 8-entry output queue
// could not hold every tick in flight.

module tick_window_signal_engine #(
  parameter int NUM_INSTRUMENTS = tws_pkg::DEF_NUM_INSTRUMENTS,
  parameter int WINDOW_LEN      = tws_pkg::DEF_WINDOW_LEN
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [tws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [tws_pkg::CFG_W-1:0]     cfg_data,
  tws_stream_if.sink                   tick,
  tws_stream_if.source                 order
);
  import tws_pkg::*;

  localparam int IW  = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int HW  = $clog2(WINDOW_LEN);
  localparam int CW  = $clog2(WINDOW_LEN + 1);
  localparam int SW  = PRICE_W + CW;
  localparam int MW  = SW + 8;
  localparam int WD  = NUM_INSTRUMENTS * WINDOW_LEN;
  localparam int WAW = $clog2(WD);
  localparam int QD  = 8;
  localparam int QAW = $clog2(QD);

  typedef struct packed {
    logic [HW-1:0]      head;
    logic [CW-1:0]      count;
    logic [SW-1:0]      sum;
    logic [PRICE_W-1:0] prev1;
    logic [PRICE_W-1:0] prev2;
  } meta_t;

  // configuration
  logic [PRICE_W-1:0] low_limit;
  logic [PRICE_W-1:0] high_limit;
  logic [BAND_W-1:0]  band;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RESET;
      high_limit <= HIGH_LIMIT_RESET;
      band       <= BAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_LIMIT:  low_limit  <= cfg_data[PRICE_W-1:0];
        CFG_HIGH_LIMIT: high_limit <= cfg_data[PRICE_W-1:0];
        CFG_BAND:       band       <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  meta_t              meta_mem [NUM_INSTRUMENTS];
  logic [PRICE_W-1:0] win_mem  [WD];
  meta_t              meta_rd;
  logic [PRICE_W-1:0] win_rd;

  logic          clearing;
  logic [IW-1:0] clr_addr;

  // pipeline registers
  logic               s1_valid, s2_valid, s3_valid, s4_valid;
  logic [INST_W-1:0]  s1_inst, s2_inst, s3_inst, s4_inst;
  logic [PRICE_W-1:0] s1_price, s2_price, s3_price, s4_price;

  logic [HW-1:0]      s2_head;
  logic [CW-1:0]      s2_count;
  logic               s2_full;
  logic [SW-1:0]      s2_sum_old;
  logic               s2_sum_fwd;
  logic [PRICE_W-1:0] s2_prev1, s2_prev2;

  logic [CW-1:0]      s3_count, s4_count;
  logic [CW+6:0]      s3_cnt100;
  logic [SW-1:0]      s3_sum, s4_sum;
  logic               s3_sig1, s3_sig3, s4_sig1, s4_sig3;
  logic [MW-1:0]      s4_lhs, s4_rlo, s4_rhi, s4_pc;

  logic               wb_valid;
  logic [IW-1:0]      wb_idx;
  meta_t              wb_meta;

  // output queue
  order_t          q_mem [QD];
  logic [QAW-1:0]  q_wr, q_rd;
  logic [QAW:0]    q_cnt;

  // accept
  logic          acc;
  logic          in_range;
  logic [IW-1:0] acc_idx;
  logic [2:0]    inflight;

  assign inflight = 3'(s1_valid) + 3'(s2_valid) + 3'(s3_valid) + 3'(s4_valid);
  assign tick.ready = !clearing && ((32'(q_cnt) + 32'(inflight)) < QD);
  assign acc = tick.valid && tick.ready;
  assign in_range = (32'(tick.payload.inst_id) < NUM_INSTRUMENTS);
  assign acc_idx = IW'(32'(tick.payload.inst_id));

  // stage 1: forwarding and window access
  logic [IW-1:0]  s1_idx;
  meta_t          m_f;
  logic           s1_fwd_s2;
  logic [WAW-1:0] win_addr;
  logic           full_f;
  meta_t          s2_new;

  assign s1_idx = IW'(32'(s1_inst));
  assign s1_fwd_s2 = s2_valid && (s2_inst == s1_inst);

  always_comb begin
    priority if (s1_fwd_s2) begin
      m_f = s2_new;
    end else if (wb_valid && (wb_idx == s1_idx)) begin
      m_f = wb_meta;
    end else begin
      m_f = meta_rd;
    end
  end

  assign full_f   = (32'(m_f.count) == WINDOW_LEN);
  assign win_addr = WAW'(32'(s1_idx) * WINDOW_LEN + 32'(m_f.head));

  // stage 2: running sum and write-back
  logic [PRICE_W-1:0] evict;
  logic [SW-1:0]      sum_base;
  logic [SW-1:0]      sum_new;
  logic [IW-1:0]      s2_idx;

  assign s2_idx   = IW'(32'(s2_inst));
  assign evict    = s2_full ? win_rd : '0;
  assign sum_base = s2_sum_fwd ? wb_meta.sum : s2_sum_old;
  assign sum_new  = sum_base - SW'(evict) + SW'(s2_price);

  always_comb begin
    s2_new.head  = s2_head;
    s2_new.count = s2_count;
    s2_new.sum   = sum_new;
    s2_new.prev1 = s2_price;
    s2_new.prev2 = s2_prev1;
  end

  always_ff @(posedge clk) begin
    meta_rd <= meta_mem[acc_idx];
    if (clearing) begin
      meta_mem[clr_addr] <= '0;
    end else if (s2_valid) begin
      meta_mem[s2_idx] <= s2_new;
    end
  end

  always_ff @(posedge clk) begin
    win_rd <= win_mem[win_addr];
    if (s1_valid) begin
      win_mem[win_addr] <= s1_price;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (32'(clr_addr) == NUM_INSTRUMENTS - 1) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // stage 4: signal decision
  logic          sig2, buy2, fire, buy;
  logic [SIG_W-1:0]   trig;
  logic [PRICE_W-1:0] ord_price;
  order_t        ord;

  assign sig2 = (32'(s4_count) >= MIN_AVG_COUNT) &&
                ((s4_lhs < s4_rlo) || (s4_lhs > s4_rhi));
  assign buy2 = (s4_pc < MW'(s4_sum));
  assign fire = s4_sig1 || sig2 || s4_sig3;
  assign buy  = s4_sig1 || s4_sig3 || (sig2 && buy2);

  always_comb begin
    priority if (s4_sig1) begin
      trig = SIG_BAND;
    end else if (sig2) begin
      trig = SIG_AVG;
    end else begin
      trig = SIG_RISE;
    end
    if (buy) begin
      ord_price = (s4_price == PRICE_MAX) ? PRICE_MAX : s4_price + 1'b1;
    end else begin
      ord_price = (s4_price == '0) ? '0 : s4_price - 1'b1;
    end
    ord.order_instrument = s4_inst;
    ord.order_price      = ord_price;
    ord.is_buy           = buy;
    ord.trigger_signal   = trig;
  end

  logic q_push, q_pop;
  assign q_push = s4_valid && fire;
  assign q_pop  = order.valid && order.ready;
  assign order.valid   = (q_cnt != '0);
  assign order.payload = q_mem[q_rd];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= ord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (q_push) q_wr <= q_wr + 1'b1;
      if (q_pop)  q_rd <= q_rd + 1'b1;
      q_cnt <= q_cnt + (QAW+1)'(q_push) - (QAW+1)'(q_pop);
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      s1_valid <= acc && in_range;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      wb_valid <= s2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_inst  <= tick.payload.inst_id;
    s1_price <= tick.payload.price;

    s2_inst    <= s1_inst;
    s2_price   <= s1_price;
    s2_full    <= full_f;
    s2_count   <= full_f ? m_f.count : m_f.count + 1'b1;
    s2_head    <= (32'(m_f.head) == WINDOW_LEN - 1) ? '0 : m_f.head + 1'b1;
    s2_sum_old <= m_f.sum;
    s2_sum_fwd <= s1_fwd_s2;
    s2_prev1   <= m_f.prev1;
    s2_prev2   <= m_f.prev2;

    wb_idx  <= s2_idx;
    wb_meta <= s2_new;

    s3_inst   <= s2_inst;
    s3_price  <= s2_price;
    s3_count  <= s2_count;
    s3_cnt100 <= (CW+7)'(s2_count) * (CW+7)'(PERCENT);
    s3_sum    <= sum_new;
    s3_sig1   <= (s2_price < low_limit) || (s2_price > high_limit);
    s3_sig3   <= (32'(s2_count) >= MIN_RISE_COUNT) &&
                 (s2_prev1 > s2_prev2) && (s2_price > s2_prev1);

    s4_inst  <= s3_inst;
    s4_price <= s3_price;
    s4_count <= s3_count;
    s4_sum   <= s3_sum;
    s4_sig1  <= s3_sig1;
    s4_sig3  <= s3_sig3;
    s4_lhs   <= MW'(s3_price) * MW'(s3_cnt100);
    s4_rlo   <= MW'(s3_sum) * MW'(PERCENT - {2'b00, band});
    s4_rhi   <= MW'(s3_sum) * MW'(PERCENT + {2'b00, band});
    s4_pc    <= MW'(s3_price) * MW'(s3_count);
  end

endmodule

`default_nettype wire
